FILE: src/utf8_to_utf16_console_decoder_top_assert.svh
// Assertion macros for the UTF-8 to UTF-16 console decoder.
// Used by the top level; expects signals named clk and arst_n in scope.
`ifndef UTF8_TO_UTF16_CONSOLE_DECODER_TOP_ASSERT_SVH
`define UTF8_TO_UTF16_CONSOLE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define U8DEC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define U8DEC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/u8dec_pkg.sv
// Shared constants and types for the UTF-8 to UTF-16 console decoder.
// No dependencies.
package u8dec_pkg;

	// Code units
	localparam logic [15:0] CU_NONCHAR = 16'hFFFE;
	localparam logic [15:0] CU_BOM     = 16'hFEFF;
	localparam logic [15:0] CU_QMARK   = 16'h003F;
	localparam logic [15:0] CU_LF      = 16'h000A;
	localparam logic [15:0] CU_CR      = 16'h000D;

	// Byte classes
	localparam logic [7:0] TRAIL_MIN = 8'h80;
	localparam logic [7:0] TRAIL_END = 8'hC0;
	localparam logic [7:0] LEAD_MIN  = 8'hC2;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD_MAX  = 8'hEF;

	// Open sequence: lead byte and first trail byte, zero when absent
	typedef struct packed {
		logic [7:0] lead;
		logic [7:0] middle;
	} u8dec_seq_t;

	// Decode result of one byte
	typedef struct packed {
		logic        emit;   // at least one code unit
		logic        nl;     // newline: CR then LF
		logic [15:0] cu;
	} u8dec_dec_t;

endpackage

FILE: src/u8dec_byte_if.sv
// Byte channel: valid/ready handshake carrying one UTF-8 byte.
// No dependencies.
interface u8dec_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: src/u8dec_unit_if.sv
// Code unit channel: valid/ready handshake carrying one UTF-16 code unit.
// No dependencies.
interface u8dec_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        last_of_run;

	modport source (output valid, output code_unit, output last_of_run, input ready);
	modport sink   (input valid, input code_unit, input last_of_run, output ready);
endinterface

FILE: src/utf8_to_utf16_console_decoder_top.sv
// UTF-8 to UTF-16 console decoder (BMP only). Accepts one byte per cycle when
// the output side keeps up, except while a newline is held; results are
// registered and appear in the cycle after the byte transfer, from a single
// output register. A newline puts CR then LF through that register, so the
// byte side stalls while the CR is held. Lead bytes, first trail bytes of
// three-byte sequences and U+FEFF produce no output. Invalid input yields '?'.
// Depends on u8dec_pkg, u8dec_byte_if, u8dec_unit_if, u8dec_decode and the
// assertion macro header.
`include "utf8_to_utf16_console_decoder_top_assert.svh"

module utf8_to_utf16_console_decoder_top (
	input  logic         clk,
	input  logic         arst_n,
	u8dec_byte_if.sink   utf8,
	u8dec_unit_if.source utf16
);

	u8dec_pkg::u8dec_seq_t seq_q;
	u8dec_pkg::u8dec_seq_t seq_next;
	u8dec_pkg::u8dec_dec_t dec;

	logic        out_valid_q;
	logic        pending_lf_q;
	logic [15:0] out_cu_q;
	logic        out_last_q;
	logic        in_xfer;
	logic        out_xfer;

	u8dec_decode u_decode (
		.in_byte  (utf8.in_byte),
		.seq      (seq_q),
		.seq_next (seq_next),
		.dec      (dec)
	);

	// Handshakes: take a byte whenever the output slot frees this cycle
	assign utf8.ready        = !out_valid_q || (utf16.ready && !pending_lf_q);
	assign in_xfer           = utf8.valid && utf8.ready;
	assign out_xfer          = out_valid_q && utf16.ready;
	assign utf16.valid       = out_valid_q;
	assign utf16.code_unit   = out_cu_q;
	assign utf16.last_of_run = out_last_q;

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (in_xfer) begin
			seq_q <= seq_next;
		end
	end

	// Output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pending_lf_q <= 1'b0;
		end else if (out_xfer && pending_lf_q) begin
			out_valid_q  <= 1'b1;
			pending_lf_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q  <= dec.emit;
			pending_lf_q <= dec.emit && dec.nl;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (out_xfer && pending_lf_q) begin
			out_cu_q   <= u8dec_pkg::CU_LF;
			out_last_q <= 1'b1;
		end else if (in_xfer && dec.emit) begin
			out_cu_q   <= dec.nl ? u8dec_pkg::CU_CR : dec.cu;
			out_last_q <= !dec.nl;
		end
	end

	// Checks
	`U8DEC_ASSERT_NOW(a_pending_is_cr, pending_lf_q,
		out_valid_q && !out_last_q && (out_cu_q == u8dec_pkg::CU_CR),
		"pending LF without CR in output register")
	`U8DEC_ASSERT_NOW(a_not_last_pending, out_valid_q && !out_last_q, pending_lf_q,
		"non-final code unit with no LF to follow")
	`U8DEC_ASSERT_NEXT(a_lf_follows, out_xfer && pending_lf_q,
		out_valid_q && out_last_q && (out_cu_q == u8dec_pkg::CU_LF) && !pending_lf_q,
		"LF did not follow CR")
	`U8DEC_ASSERT_NOW(a_middle_needs_lead3, seq_q.middle != 8'h00,
		seq_q.lead >= u8dec_pkg::LEAD3_MIN,
		"trail byte stored without a three-byte lead")
	`U8DEC_ASSERT_NEXT(a_lead_stored,
		in_xfer && (utf8.in_byte >= u8dec_pkg::LEAD_MIN) &&
		(utf8.in_byte <= u8dec_pkg::LEAD_MAX),
		(seq_q.lead == $past(utf8.in_byte)) && (seq_q.middle == 8'h00) && !out_valid_q,
		"lead byte not held or produced output")

endmodule

FILE: src/u8dec_decode.sv
// Combinational UTF-8 byte decoder: next sequence state and emitted code unit.
// Depends on u8dec_pkg.
module u8dec_decode (
	input  logic [7:0]          in_byte,
	input  u8dec_pkg::u8dec_seq_t seq,
	output u8dec_pkg::u8dec_seq_t seq_next,
	output u8dec_pkg::u8dec_dec_t dec
);

	logic [15:0] cu_raw;
	logic        emit_raw;

	// Sequence tracking
	always_comb begin
		cu_raw   = u8dec_pkg::CU_NONCHAR;
		emit_raw = 1'b1;
		seq_next = '0;
		if (in_byte < u8dec_pkg::TRAIL_MIN) begin
			// ASCII; mid-sequence it is dropped and flagged
			if (seq.lead == 8'h00) begin
				cu_raw = {8'h00, in_byte};
			end
		end else if (in_byte < u8dec_pkg::TRAIL_END) begin
			if (seq.lead == 8'h00) begin
				// stray trail byte: stays invalid
			end else if (seq.lead < u8dec_pkg::LEAD3_MIN) begin
				cu_raw = {5'd0, seq.lead[4:0], in_byte[5:0]};
			end else if (seq.middle == 8'h00) begin
				seq_next.lead   = seq.lead;
				seq_next.middle = in_byte;
				emit_raw        = 1'b0;
			end else begin
				cu_raw = {seq.lead[3:0], seq.middle[5:0], in_byte[5:0]};
			end
		end else if (in_byte inside {[u8dec_pkg::LEAD_MIN:u8dec_pkg::LEAD_MAX]}) begin
			seq_next.lead = in_byte;
			emit_raw      = 1'b0;
		end
		// C0, C1 and F0..FF fall through: invalid, sequence cleared
	end

	// Output filtering: noncharacter, byte order mark, newline
	always_comb begin
		dec.cu   = (cu_raw == u8dec_pkg::CU_NONCHAR) ? u8dec_pkg::CU_QMARK : cu_raw;
		dec.emit = emit_raw && (cu_raw != u8dec_pkg::CU_BOM);
		dec.nl   = (cu_raw == u8dec_pkg::CU_LF);
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf8_to_utf16_console_decoder_top: a directed byte table,
// then random UTF-8 streams, checked against table entries or a behavioral decoder model.
// Depends on u8dec_pkg, u8dec_byte_if, u8dec_unit_if and the decoder top level.
module testbench;

	localparam int N_DIRECTED  = 29;
	localparam int N_RANDOM    = 400;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 20;

	// One stimulus byte; when fixed is set, n/cu0/cu1 hold the expected code units
	typedef struct packed {
		logic [7:0]  b;
		logic        fixed;
		logic [1:0]  n;
		logic [15:0] cu0;
		logic [15:0] cu1;
	} stim_row_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        last_of_run;
	} unit_t;

	logic clk;
	logic arst_n;

	u8dec_byte_if byte_ch ();
	u8dec_unit_if unit_ch ();

	utf8_to_utf16_console_decoder_top u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.utf8  (byte_ch),
		.utf16 (unit_ch)
	);

	// Directed bytes: extremes, invalid bytes and every special sequence
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{8'h00, 1'b1, 2'd1, 16'h0000, 16'h0000},  // NUL passes through
		'{8'h0A, 1'b1, 2'd2, u8dec_pkg::CU_CR, u8dec_pkg::CU_LF},  // newline: CR then LF
		'{8'h80, 1'b1, 2'd1, u8dec_pkg::CU_QMARK, 16'h0000},  // stray trail
		'{8'hC0, 1'b1, 2'd1, u8dec_pkg::CU_QMARK, 16'h0000},  // never-valid byte
		'{8'hFF, 1'b1, 2'd1, u8dec_pkg::CU_QMARK, 16'h0000},  // never-valid byte
		'{8'hC2, 1'b1, 2'd0, 16'h0000, 16'h0000},  // lowest lead: silent
		'{8'h80, 1'b0, 2'd0, 16'h0000, 16'h0000},  // U+0080
		'{8'hDF, 1'b1, 2'd0, 16'h0000, 16'h0000},
		'{8'hBF, 1'b0, 2'd0, 16'h0000, 16'h0000},  // U+07FF
		'{8'hC3, 1'b1, 2'd0, 16'h0000, 16'h0000},
		'{8'h41, 1'b1, 2'd1, u8dec_pkg::CU_QMARK, 16'h0000},  // ASCII inside a sequence
		'{8'hEF, 1'b1, 2'd0, 16'h0000, 16'h0000},
		'{8'hBB, 1'b1, 2'd0, 16'h0000, 16'h0000},  // first trail: silent
		'{8'hBF, 1'b1, 2'd0, 16'h0000, 16'h0000},  // byte order mark: silent
		'{8'hEF, 1'b1, 2'd0, 16'h0000, 16'h0000},
		'{8'hBF, 1'b1, 2'd0, 16'h0000, 16'h0000},
		'{8'hBE, 1'b1, 2'd1, u8dec_pkg::CU_QMARK, 16'h0000},  // U+FFFE becomes '?'
		'{8'hE0, 1'b1, 2'd0, 16'h0000, 16'h0000},
		'{8'h80, 1'b1, 2'd0, 16'h0000, 16'h0000},
		'{8'h8A, 1'b1, 2'd2, u8dec_pkg::CU_CR, u8dec_pkg::CU_LF},  // overlong newline
		'{8'hED, 1'b1, 2'd0, 16'h0000, 16'h0000},
		'{8'hA0, 1'b1, 2'd0, 16'h0000, 16'h0000},
		'{8'h80, 1'b0, 2'd0, 16'h0000, 16'h0000},  // surrogate passes through
		'{8'hC2, 1'b1, 2'd0, 16'h0000, 16'h0000},
		'{8'hE3, 1'b1, 2'd0, 16'h0000, 16'h0000},  // new lead replaces the open one
		'{8'h81, 1'b1, 2'd0, 16'h0000, 16'h0000},
		'{8'h81, 1'b0, 2'd0, 16'h0000, 16'h0000},
		'{8'hE5, 1'b1, 2'd0, 16'h0000, 16'h0000},
		'{8'hC1, 1'b1, 2'd1, u8dec_pkg::CU_QMARK, 16'h0000}   // invalid byte inside a sequence
	};

	stim_row_t             byte_stream [$];
	unit_t                 pending_units [$];
	u8dec_pkg::u8dec_seq_t open_seq;
	int                    n_errors;
	int                    units_seen;
	int                    newline_pairs;
	int                    cycle_count;

	// Decoder model: updates open_seq, returns the number of code units
	function automatic int decode_utf8_byte(input logic [7:0] b, output logic [15:0] first,
			output logic [15:0] second);
		logic [15:0] cu;
		logic        quiet;
		cu     = u8dec_pkg::CU_NONCHAR;
		quiet  = 1'b0;
		first  = 16'h0000;
		second = 16'h0000;
		if (b < u8dec_pkg::TRAIL_MIN) begin
			if (open_seq.lead == 8'h00)
				cu = {8'h00, b};
			else
				open_seq = '0;
		end else if (b < u8dec_pkg::TRAIL_END) begin
			if (open_seq.lead == 8'h00) begin
				// stray trail stays invalid
			end else if (open_seq.lead < u8dec_pkg::LEAD3_MIN) begin
				cu = {5'b00000, open_seq.lead[4:0], b[5:0]};
				open_seq = '0;
			end else if (open_seq.middle == 8'h00) begin
				open_seq.middle = b;
				quiet = 1'b1;
			end else begin
				cu = {open_seq.lead[3:0], open_seq.middle[5:0], b[5:0]};
				open_seq = '0;
			end
		end else if (b >= u8dec_pkg::LEAD_MIN && b <= u8dec_pkg::LEAD_MAX) begin
			open_seq.lead   = b;
			open_seq.middle = 8'h00;
			quiet = 1'b1;
		end else begin
			open_seq = '0;
		end
		if (quiet)
			return 0;
		if (cu == u8dec_pkg::CU_NONCHAR)
			cu = u8dec_pkg::CU_QMARK;
		if (cu == u8dec_pkg::CU_BOM)
			return 0;
		if (cu == u8dec_pkg::CU_LF) begin
			first  = u8dec_pkg::CU_CR;
			second = u8dec_pkg::CU_LF;
			return 2;
		end
		first = cu;
		return 1;
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		byte_stream.push_back('{b, 1'b0, 2'd0, 16'h0000, 16'h0000});
	endfunction

	function automatic logic [7:0] rand_trail();
		return 8'($urandom_range(8'h80, 8'hBF));
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Reset, once
	initial begin
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles", cycle_count);
		$display("Mismatches found");
		$finish;
	end

	// Byte sender: bursts with gaps; predicts on every transfer
	initial begin
		stim_row_t   row;
		logic [15:0] unit_a;
		logic [15:0] unit_b;
		logic [7:0]  lead;
		int          n_units;
		int          pick;
		int          issued;
		int          sent;
		int          burst_left;
		int          gap_left;
		byte_ch.valid   <= 1'b0;
		byte_ch.in_byte <= 8'h00;
		open_seq      = '0;
		n_errors      = 0;
		newline_pairs = 0;
		for (int i = 0; i < N_DIRECTED; i++)
			byte_stream.push_back(directed_rows[i]);

		// Random stream: mostly well-formed characters, some broken and noise
		while (byte_stream.size() < N_DIRECTED + N_RANDOM) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				add_byte(($urandom_range(0, 9) == 0) ? 8'h0A : 8'($urandom_range(0, 127)));
			end else if (pick < 50) begin
				add_byte(8'($urandom_range(8'hC2, 8'hDF)));
				add_byte(rand_trail());
			end else if (pick < 72) begin
				add_byte(8'($urandom_range(8'hE0, 8'hEF)));
				add_byte(rand_trail());
				add_byte(rand_trail());
			end else if (pick < 76) begin
				// byte order mark, noncharacter, overlong newline
				case ($urandom_range(0, 2))
					0: begin add_byte(8'hEF); add_byte(8'hBB); add_byte(8'hBF); end
					1: begin add_byte(8'hEF); add_byte(8'hBF); add_byte(8'hBE); end
					default: begin add_byte(8'hE0); add_byte(8'h80); add_byte(8'h8A); end
				endcase
			end else if (pick < 86) begin
				// truncated sequence cut by ASCII, an invalid byte or a new lead
				lead = 8'($urandom_range(8'hC2, 8'hEF));
				add_byte(lead);
				if (lead >= u8dec_pkg::LEAD3_MIN && $urandom_range(0, 1) == 1)
					add_byte(rand_trail());
				case ($urandom_range(0, 2))
					0: add_byte(8'($urandom_range(0, 127)));
					1: add_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'hC0, 8'hC1))
						: 8'($urandom_range(8'hF0, 8'hFF)));
					default: add_byte(8'($urandom_range(8'hC2, 8'hEF)));
				endcase
			end else if (pick < 93) begin
				add_byte(rand_trail());
			end else begin
				add_byte(8'($urandom_range(0, 255)));
			end
		end

		wait (arst_n === 1'b1);
		issued     = 0;
		sent       = 0;
		burst_left = 0;
		gap_left   = 0;
		while (sent < byte_stream.size()) begin
			@(posedge clk);
			// transfer: predict the code units it causes
			if (byte_ch.valid && byte_ch.ready) begin
				row = byte_stream[sent];
				n_units = decode_utf8_byte(row.b, unit_a, unit_b);
				if (row.fixed) begin
					n_units = row.n;
					unit_a  = row.cu0;
					unit_b  = row.cu1;
				end
				if (n_units == 1) begin
					pending_units.push_back(unit_t'{unit_a, 1'b1});
				end else if (n_units == 2) begin
					pending_units.push_back(unit_t'{unit_a, 1'b0});
					pending_units.push_back(unit_t'{unit_b, 1'b1});
					newline_pairs++;
				end
				sent++;
			end
			// slot free: next byte or an idle cycle
			if (!byte_ch.valid || byte_ch.ready) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
				if (burst_left > 0 && issued < byte_stream.size()) begin
					byte_ch.valid   <= 1'b1;
					byte_ch.in_byte <= byte_stream[issued].b;
					issued++;
					burst_left--;
				end else begin
					byte_ch.valid <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end
			end
		end

		// drain, then allow for stray output
		while (pending_units.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Covered %0d byte transfers (%0d directed, %0d random) in %0d cycles",
			sent, N_DIRECTED, sent - N_DIRECTED, cycle_count);
		$display("Checked %0d code units, %0d of them CR-LF pairs", units_seen, newline_pairs);
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Code unit receiver: stalls on a rotating mask, checks every transfer
	initial begin
		unit_t       want;
		logic [7:0]  stall_mask;
		int          rx_cycle;
		unit_ch.ready <= 1'b0;
		units_seen = 0;
		stall_mask = 8'hFF;
		rx_cycle   = 0;
		forever begin
			@(posedge clk);
			if (arst_n && unit_ch.valid && unit_ch.ready) begin
				units_seen++;
				if (pending_units.size() == 0) begin
					$error("unexpected code unit %h, last_of_run %b",
						unit_ch.code_unit, unit_ch.last_of_run);
					n_errors++;
				end else begin
					want = pending_units.pop_front();
					if (unit_ch.code_unit !== want.code_unit) begin
						$error("code_unit: expected %h, actual %h",
							want.code_unit, unit_ch.code_unit);
						n_errors++;
					end
					if (unit_ch.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %b, actual %b",
							want.last_of_run, unit_ch.last_of_run);
						n_errors++;
					end
				end
			end
			// stall pattern redrawn at random from four kinds; some phases never stall
			rx_cycle++;
			if (rx_cycle % 64 == 0) begin
				case ($urandom_range(0, 3))
					0: stall_mask = 8'hFF;
					1: stall_mask = 8'($urandom_range(1, 255));
					2: stall_mask = 8'b0101_0101;
					default: stall_mask = 8'($urandom_range(0, 255)) | 8'($urandom_range(0, 255));
				endcase
				if (stall_mask == 8'h00)
					stall_mask = 8'h01;
			end
			unit_ch.ready <= stall_mask[rx_cycle[2:0]];
		end
	end

endmodule
